// ----- design/owbm_pkg.sv -----
// One-wire bus master: shared phase codes, command kinds, register indexes,
// step state and result types. No dependencies.
`default_nettype none
package owbm_pkg;

	localparam int unsigned READ_HOLD_TICKS = 55;
	localparam int unsigned TICK_W = 10;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_RESET = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_HIGH = 4'd3;
	localparam logic [3:0] PH_RST_HOLD = 4'd4;
	localparam logic [3:0] PH_W_LOW    = 4'd5;
	localparam logic [3:0] PH_W_HOLD   = 4'd6;
	localparam logic [3:0] PH_W_REC    = 4'd7;
	localparam logic [3:0] PH_R_LOW    = 4'd8;
	localparam logic [3:0] PH_R_WAIT   = 4'd9;
	localparam logic [3:0] PH_R_HOLD   = 4'd10;

	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] REG_PRESENCE_HOLD = 3'd2;
	localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd3;
	localparam logic [2:0] REG_SLOT_HOLD     = 3'd4;
	localparam logic [2:0] REG_RECOVERY      = 3'd5;
	localparam logic [2:0] REG_READ_LOW      = 3'd6;
	localparam logic [2:0] REG_READ_SAMPLE   = 3'd7;

	localparam logic [TICK_W-1:0] READ_HOLD_LIMIT = TICK_W'(READ_HOLD_TICKS + 1);
	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef struct packed {
		logic [TICK_W-1:0] reset_low;
		logic [TICK_W-1:0] presence_wait;
		logic [TICK_W-1:0] presence_hold;
		logic [TICK_W-1:0] write_one_low;
		logic [TICK_W-1:0] slot_hold;
		logic [TICK_W-1:0] recovery;
		logic [TICK_W-1:0] read_low;
		logic [TICK_W-1:0] read_sample;
	} owbm_cfg_t;

	typedef struct packed {
		logic [3:0]        phase;
		logic [TICK_W-1:0] tick_count;
		logic [2:0]        bit_index;
		logic [7:0]        shift_reg;
		logic              last_flag;
	} owbm_state_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tx_byte;
		logic       line_level;
		logic       last_byte;
	} owbm_req_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       byte_done;
		logic [7:0] rx_byte;
		logic       transfer_done;
	} owbm_res_t;

endpackage
`default_nettype wire

// ----- design/owbm_step.sv -----
// One-wire bus master: next-state and result logic for one request.
// Depends on owbm_pkg.
`default_nettype none
module owbm_step import owbm_pkg::*; (
	input  owbm_cfg_t   cfg,
	input  owbm_state_t st,
	input  owbm_req_t   req,
	output owbm_state_t nx,
	output owbm_res_t   res
);

	logic [3:0]        ph;
	logic [TICK_W-1:0] lim;
	logic [TICK_W:0]   cnt_n;
	logic              hit;
	logic [TICK_W-1:0] cnt_next;
	logic [7:0]        sh_next;

	always_comb begin
		ph = (st.phase > PH_R_HOLD) ? PH_IDLE : st.phase;
		unique case (ph)
			PH_RST_LOW:  lim = cfg.reset_low;
			PH_RST_WAIT: lim = cfg.presence_wait;
			PH_RST_HOLD: lim = cfg.presence_hold;
			PH_W_LOW:    lim = cfg.write_one_low;
			PH_W_HOLD:   lim = cfg.slot_hold;
			PH_W_REC:    lim = cfg.recovery;
			PH_R_LOW:    lim = cfg.read_low;
			PH_R_WAIT:   lim = cfg.read_sample;
			PH_R_HOLD:   lim = READ_HOLD_LIMIT;
			default:     lim = '0;
		endcase
		cnt_n    = {1'b0, st.tick_count} + (TICK_W+1)'(1);
		hit      = cnt_n >= {1'b0, lim};
		cnt_next = hit ? '0 : cnt_n[TICK_W-1:0];
		sh_next  = {1'b0, st.shift_reg[7:1]};
	end

	always_comb begin
		nx = st;
		nx.phase = ph;
		res = '0;
		if (req.kind != KIND_TICK) begin
			if (ph == PH_IDLE) begin
				nx.tick_count = '0;
				nx.bit_index  = '0;
				unique case (req.kind)
					KIND_RESET: begin
						nx.last_flag = 1'b0;
						nx.shift_reg = '0;
						nx.phase     = PH_RST_LOW;
					end
					KIND_WRITE: begin
						nx.last_flag = req.last_byte;
						nx.shift_reg = req.tx_byte;
						nx.phase     = req.tx_byte[0] ? PH_W_LOW : PH_W_HOLD;
					end
					default: begin
						nx.last_flag = req.last_byte;
						nx.shift_reg = '0;
						nx.phase     = PH_R_LOW;
					end
				endcase
			end
		end else begin
			unique case (ph)
				PH_RST_LOW, PH_RST_WAIT, PH_W_LOW, PH_W_HOLD, PH_R_LOW: begin
					nx.tick_count = cnt_next;
					if (hit) begin
						unique case (ph)
							PH_RST_LOW:  nx.phase = PH_RST_WAIT;
							PH_RST_WAIT: nx.phase = PH_RST_HIGH;
							PH_W_LOW:    nx.phase = PH_W_HOLD;
							PH_W_HOLD:   nx.phase = PH_W_REC;
							default:     nx.phase = PH_R_WAIT;
						endcase
					end
				end
				PH_RST_HIGH: begin
					if (req.line_level) begin
						nx.tick_count = '0;
						nx.phase      = PH_RST_HOLD;
					end
				end
				PH_RST_HOLD: begin
					nx.tick_count = cnt_next;
					if (hit) begin
						nx.phase      = PH_IDLE;
						res.byte_done = 1'b1;
					end
				end
				PH_W_REC: begin
					nx.tick_count = cnt_next;
					if (hit) begin
						nx.shift_reg = sh_next;
						if (st.bit_index >= LAST_BIT) begin
							nx.bit_index      = '0;
							nx.phase          = PH_IDLE;
							res.byte_done     = 1'b1;
							res.transfer_done = st.last_flag;
						end else begin
							nx.bit_index  = st.bit_index + 3'd1;
							nx.tick_count = '0;
							nx.phase      = sh_next[0] ? PH_W_LOW : PH_W_HOLD;
						end
					end
				end
				PH_R_WAIT: begin
					nx.tick_count = cnt_next;
					if (hit) begin
						nx.shift_reg = {req.line_level, st.shift_reg[7:1]};
						nx.phase     = PH_R_HOLD;
					end
				end
				PH_R_HOLD: begin
					nx.tick_count = cnt_next;
					if (hit) begin
						if (st.bit_index >= LAST_BIT) begin
							nx.bit_index      = '0;
							nx.phase          = PH_IDLE;
							res.byte_done     = 1'b1;
							res.rx_byte       = st.shift_reg;
							res.transfer_done = st.last_flag;
						end else begin
							nx.bit_index = st.bit_index + 3'd1;
							nx.phase     = PH_R_LOW;
						end
					end
				end
				default: ;
			endcase
		end

		unique case (nx.phase)
			PH_RST_LOW, PH_W_LOW, PH_R_LOW: res.drive_low = 1'b1;
			PH_W_HOLD:                      res.drive_low = ~nx.shift_reg[0];
			default:                        res.drive_low = 1'b0;
		endcase
		res.busy_res = (nx.phase != PH_IDLE);
	end

endmodule
`default_nettype wire

// ----- design/one_wire_bus_master.sv -----
// One-wire bus master top level: input register, step logic, result register
// and configuration registers. Depends on owbm_pkg and owbm_step.
//
//  channel   | handshake                     | payload
//  s_axis    | s_axis_tvalid / s_axis_tready | tdata, tuser (kind), tlast (last_byte)
//  m_axis    | m_axis_tvalid / m_axis_tready | tdata, tlast (transfer_done)
//  cfg       | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// Every request yields one result: the step logic is a single pass from the input
// register to the result register. One request per cycle is sustained while results
// are not stalled. Reset loads the default tick counts and idles the bus. A stalled
// result holds its register and a full input register; cfg_ready is always high.
`default_nettype none
module one_wire_bus_master import owbm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] line_level, [15:9] zero
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [0] drive_low, [1] busy_res, [2] byte_done,
	                                        // [10:3] rx_byte, [15:11] zero
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [TICK_W-1:0] cfg_data
);

	owbm_cfg_t   cfg_q;
	owbm_state_t state_q;
	owbm_state_t nx;
	owbm_req_t   req_s1;
	owbm_res_t   res;
	owbm_res_t   res_s2;
	logic        vld_s1;
	logic        vld_s2;
	logic        adv;

	assign adv           = ~vld_s2 | m_axis_tready;
	assign s_axis_tready = ~vld_s1 | adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low     <= TICK_W'(480);
			cfg_q.presence_wait <= TICK_W'(60);
			cfg_q.presence_hold <= TICK_W'(420);
			cfg_q.write_one_low <= TICK_W'(2);
			cfg_q.slot_hold     <= TICK_W'(60);
			cfg_q.recovery      <= TICK_W'(2);
			cfg_q.read_low      <= TICK_W'(2);
			cfg_q.read_sample   <= TICK_W'(10);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESET_LOW:     cfg_q.reset_low     <= cfg_data;
				REG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_data;
				REG_PRESENCE_HOLD: cfg_q.presence_hold <= cfg_data;
				REG_WRITE_ONE_LOW: cfg_q.write_one_low <= cfg_data;
				REG_SLOT_HOLD:     cfg_q.slot_hold     <= cfg_data;
				REG_RECOVERY:      cfg_q.recovery      <= cfg_data;
				REG_READ_LOW:      cfg_q.read_low      <= cfg_data;
				REG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.kind       <= s_axis_tuser;
			req_s1.tx_byte    <= s_axis_tdata[7:0];
			req_s1.line_level <= s_axis_tdata[8];
			req_s1.last_byte  <= s_axis_tlast;
		end
	end

	owbm_step u_step (
		.cfg (cfg_q),
		.st  (state_q),
		.req (req_s1),
		.nx  (nx),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (adv) begin
			vld_s2 <= vld_s1;
			if (vld_s1) begin
				state_q <= nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {5'd0, res_s2.rx_byte, res_s2.byte_done,
	                        res_s2.busy_res, res_s2.drive_low};
	assign m_axis_tlast  = res_s2.transfer_done;

`ifndef SYNTHESIS
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase <= PH_R_HOLD)
		else $error("phase out of range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.byte_done |-> !res_s2.busy_res && !res_s2.drive_low)
		else $error("byte_done while busy or driving");

	a_tdone_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && res_s2.transfer_done |-> res_s2.byte_done)
		else $error("transfer_done without byte_done");

	a_rx_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && (res_s2.rx_byte != 8'd0) |-> res_s2.byte_done)
		else $error("rx_byte set without byte_done");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |=> $stable(state_q))
		else $error("state moved with no request");
`endif

endmodule
`default_nettype wire

// ----- sim/one_wire_bus_master_tb.sv -----
// Self-checking bench for the one-wire bus master: directed rows, then random command
// sequences under several timing settings, each result checked against a local predictor or a fixed value.
// Depends on owbm_pkg and the one_wire_bus_master RTL.
`timescale 1ns / 1ps
module one_wire_bus_master_tb;
	import owbm_pkg::*;

	localparam int CFG_SHORT = 0;
	localparam int CFG_MAX   = 1;
	localparam int CFG_ZERO  = 2;
	localparam owbm_res_t RES_IDLE     = '0;
	localparam owbm_res_t RES_LOW_BUSY = owbm_res_t'({1'b1, 1'b1, 1'b0, 8'h00, 1'b0});

	typedef struct packed {
		bit                is_cfg;
		logic [2:0]        cfg_idx;
		logic [TICK_W-1:0] cfg_val;
		owbm_req_t         req;
		bit                typed;
		owbm_res_t         want;
	} step_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;
	logic [1:0]        s_axis_tuser = KIND_TICK;
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [15:0]       m_axis_tdata;
	logic              m_axis_tlast;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = REG_RESET_LOW;
	logic [TICK_W-1:0] cfg_data = '0;

	// predicted bus master state and timing registers
	logic [3:0]        bus_phase;
	int unsigned       tick_cnt;
	logic [2:0]        bit_idx;
	logic [7:0]        shift_byte;
	logic              last_mark;
	logic [TICK_W-1:0] tick_cfg [8];

	owbm_res_t         expected_bus_results [$];
	step_row_t         directed_rows [$];
	int                mismatch_count = 0;
	int                requests_sent = 0;
	int                rcv_cycles = 0;

	one_wire_bus_master i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bit limit_reached(int unsigned limit);
		int unsigned n;
		n = tick_cnt + 1;
		if (n >= limit) begin
			tick_cnt = 0;
			return 1'b1;
		end
		tick_cnt = n;
		return 1'b0;
	endfunction

	function automatic void start_bit_slot();
		tick_cnt = 0;
		bus_phase = shift_byte[0] ? PH_W_LOW : PH_W_HOLD;
	endfunction

	function automatic owbm_res_t predict_bus_step(owbm_req_t r);
		owbm_res_t res;
		res = '0;
		if (r.kind != KIND_TICK) begin
			if (bus_phase == PH_IDLE) begin
				tick_cnt = 0;
				bit_idx = '0;
				case (r.kind)
					KIND_RESET: begin
						last_mark = 1'b0;
						shift_byte = '0;
						bus_phase = PH_RST_LOW;
					end
					KIND_WRITE: begin
						last_mark = r.last_byte;
						shift_byte = r.tx_byte;
						start_bit_slot();
					end
					default: begin
						last_mark = r.last_byte;
						shift_byte = '0;
						bus_phase = PH_R_LOW;
					end
				endcase
			end
		end else begin
			case (bus_phase)
				PH_RST_LOW:
					if (limit_reached(tick_cfg[REG_RESET_LOW])) bus_phase = PH_RST_WAIT;
				PH_RST_WAIT:
					if (limit_reached(tick_cfg[REG_PRESENCE_WAIT])) bus_phase = PH_RST_HIGH;
				PH_RST_HIGH:
					if (r.line_level) begin
						tick_cnt = 0;
						bus_phase = PH_RST_HOLD;
					end
				PH_RST_HOLD:
					if (limit_reached(tick_cfg[REG_PRESENCE_HOLD])) begin
						bus_phase = PH_IDLE;
						res.byte_done = 1'b1;
					end
				PH_W_LOW:
					if (limit_reached(tick_cfg[REG_WRITE_ONE_LOW])) bus_phase = PH_W_HOLD;
				PH_W_HOLD:
					if (limit_reached(tick_cfg[REG_SLOT_HOLD])) bus_phase = PH_W_REC;
				PH_W_REC:
					if (limit_reached(tick_cfg[REG_RECOVERY])) begin
						shift_byte = shift_byte >> 1;
						if (bit_idx == LAST_BIT) begin
							bit_idx = '0;
							bus_phase = PH_IDLE;
							res.byte_done = 1'b1;
							res.transfer_done = last_mark;
						end else begin
							bit_idx = bit_idx + 3'd1;
							start_bit_slot();
						end
					end
				PH_R_LOW:
					if (limit_reached(tick_cfg[REG_READ_LOW])) bus_phase = PH_R_WAIT;
				PH_R_WAIT:
					if (limit_reached(tick_cfg[REG_READ_SAMPLE])) begin
						shift_byte = {r.line_level, shift_byte[7:1]};
						bus_phase = PH_R_HOLD;
					end
				PH_R_HOLD:
					if (limit_reached(READ_HOLD_TICKS + 1)) begin
						if (bit_idx == LAST_BIT) begin
							bit_idx = '0;
							bus_phase = PH_IDLE;
							res.byte_done = 1'b1;
							res.rx_byte = shift_byte;
							res.transfer_done = last_mark;
						end else begin
							bit_idx = bit_idx + 3'd1;
							bus_phase = PH_R_LOW;
						end
					end
				default: ;
			endcase
		end
		case (bus_phase)
			PH_RST_LOW, PH_W_LOW, PH_R_LOW: res.drive_low = 1'b1;
			PH_W_HOLD: res.drive_low = ~shift_byte[0];
			default: res.drive_low = 1'b0;
		endcase
		res.busy_res = (bus_phase != PH_IDLE);
		return res;
	endfunction

	// mostly well-formed: commands when idle, ticks while busy, a few stray commands
	function automatic owbm_req_t next_bus_request();
		owbm_req_t   r;
		int unsigned roll;
		r.tx_byte = 8'($urandom_range(0, 255));
		r.last_byte = 1'($urandom_range(0, 1));
		r.line_level = 1'($urandom_range(0, 1));
		r.kind = KIND_TICK;
		roll = $urandom_range(0, 99);
		if (bus_phase == PH_IDLE) begin
			if (roll < 25) r.kind = KIND_RESET;
			else if (roll < 55) r.kind = KIND_WRITE;
			else if (roll < 80) r.kind = KIND_READ;
		end else if (roll < 5) begin
			r.kind = (roll < 2) ? KIND_RESET : (roll < 4) ? KIND_WRITE : KIND_READ;
		end else if (bus_phase == PH_RST_HIGH) begin
			r.line_level = ($urandom_range(0, 99) < 65);
		end
		return r;
	endfunction

	function automatic step_row_t item_row(logic [1:0] kind, logic [7:0] tx, logic line,
			logic last, bit typed, owbm_res_t want);
		step_row_t row;
		row = '0;
		row.req.kind = kind;
		row.req.tx_byte = tx;
		row.req.line_level = line;
		row.req.last_byte = last;
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	function automatic step_row_t cfg_row(logic [2:0] idx, logic [TICK_W-1:0] val);
		step_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = val;
		return row;
	endfunction

	task automatic send_request(owbm_req_t r, bit typed, owbm_res_t want);
		owbm_res_t predicted;
		if (!(requests_sent >= 300 && requests_sent < 450) && $urandom_range(0, 99) < 14) begin
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, r.line_level, r.tx_byte};
		s_axis_tuser <= r.kind;
		s_axis_tlast <= r.last_byte;
		do @(posedge clk); while (!s_axis_tready);
		predicted = predict_bus_step(r);
		expected_bus_results.push_back(typed ? want : predicted);
		requests_sent++;
	endtask

	// stop offering and wait until every outstanding request has its result
	task automatic settle_bus();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (expected_bus_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_tick_reg(logic [2:0] idx, logic [TICK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		tick_cfg[idx] = val;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic load_tick_cfg(int mode);
		logic [TICK_W-1:0] val;
		for (int i = 0; i < 8; i++) begin
			if (mode == CFG_MAX) val = '1;
			else if (mode == CFG_ZERO) val = '0;
			else if ($urandom_range(0, 7) == 0) val = TICK_W'($urandom_range(0, 60));
			else val = TICK_W'($urandom_range(0, 6));
			write_tick_reg(3'(i), val);
		end
	endtask

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// receiver: random stalls, a periodic long hold-off, one stall-free stretch
	always @(negedge clk) begin
		rcv_cycles <= rcv_cycles + 1;
		if (rcv_cycles % 1000 >= 200 && rcv_cycles % 1000 < 260)
			m_axis_tready <= 1'b0;
		else if (rcv_cycles >= 500 && rcv_cycles < 800)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= 22);
	end

	always @(posedge clk) begin
		owbm_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bus_results.size() == 0) begin
				$error("result with no request pending");
				mismatch_count++;
			end else begin
				want = expected_bus_results.pop_front();
				compare_field("drive_low", want.drive_low, m_axis_tdata[0]);
				compare_field("busy_res", want.busy_res, m_axis_tdata[1]);
				compare_field("byte_done", want.byte_done, m_axis_tdata[2]);
				compare_field("rx_byte", want.rx_byte, m_axis_tdata[10:3]);
				compare_field("transfer_done", want.transfer_done, m_axis_tlast);
			end
		end
	end

	initial begin
		step_row_t row;
		owbm_req_t req;
		int        phase_no;
		int        phase_items;
		int        phase_target;

		bus_phase = PH_IDLE;
		tick_cnt = 0;
		bit_idx = '0;
		shift_byte = '0;
		last_mark = 1'b0;
		tick_cfg[REG_RESET_LOW] = 10'd480;
		tick_cfg[REG_PRESENCE_WAIT] = 10'd60;
		tick_cfg[REG_PRESENCE_HOLD] = 10'd420;
		tick_cfg[REG_WRITE_ONE_LOW] = 10'd2;
		tick_cfg[REG_SLOT_HOLD] = 10'd60;
		tick_cfg[REG_RECOVERY] = 10'd2;
		tick_cfg[REG_READ_LOW] = 10'd2;
		tick_cfg[REG_READ_SAMPLE] = 10'd10;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// defaults after reset: idle ticks, reset start, commands while busy
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 1, RES_IDLE));
		directed_rows.push_back(item_row(KIND_TICK, 8'hFF, 1'b1, 1'b1, 1, RES_IDLE));
		directed_rows.push_back(item_row(KIND_RESET, 8'h00, 1'b0, 1'b0, 1, RES_LOW_BUSY));
		directed_rows.push_back(item_row(KIND_WRITE, 8'hFF, 1'b1, 1'b1, 1, RES_LOW_BUSY));
		directed_rows.push_back(item_row(KIND_READ, 8'h5A, 1'b0, 1'b1, 1, RES_LOW_BUSY));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		// short timing, zero counts act as one tick
		directed_rows.push_back(cfg_row(REG_RESET_LOW, 10'd0));
		directed_rows.push_back(cfg_row(REG_PRESENCE_WAIT, 10'd1));
		directed_rows.push_back(cfg_row(REG_PRESENCE_HOLD, 10'd2));
		directed_rows.push_back(cfg_row(REG_WRITE_ONE_LOW, 10'd1));
		directed_rows.push_back(cfg_row(REG_SLOT_HOLD, 10'd1));
		directed_rows.push_back(cfg_row(REG_RECOVERY, 10'd0));
		directed_rows.push_back(cfg_row(REG_READ_LOW, 10'd1));
		directed_rows.push_back(cfg_row(REG_READ_SAMPLE, 10'd1));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		// line held low after presence wait
		directed_rows.push_back(item_row(KIND_TICK, 8'hFF, 1'b0, 1'b1, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'hFF, 1'b0, 1'b1, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		directed_rows.push_back(item_row(KIND_WRITE, 8'hFF, 1'b0, 1'b1, 0, '0));
		directed_rows.push_back(item_row(KIND_READ, 8'h00, 1'b1, 1'b0, 0, '0));
		for (int i = 0; i < 5; i++)
			directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 0, '0));
		directed_rows.push_back(item_row(KIND_RESET, 8'h81, 1'b1, 1'b1, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b1, 1'b0, 0, '0));
		directed_rows.push_back(item_row(KIND_TICK, 8'h00, 1'b0, 1'b0, 0, '0));

		for (int i = 0; i < directed_rows.size(); i++) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				settle_bus();
				write_tick_reg(row.cfg_idx, row.cfg_val);
			end else begin
				send_request(row.req, row.typed, row.want);
			end
		end

		for (phase_no = 0; phase_no < 3; phase_no++) begin
			settle_bus();
			if (phase_no == 1) begin
				load_tick_cfg(CFG_MAX);
				phase_target = 200;
			end else if (phase_no == 2) begin
				load_tick_cfg(CFG_ZERO);
				phase_target = 250;
			end else begin
				load_tick_cfg(CFG_SHORT);
				phase_target = 370;
			end
			for (phase_items = 0; phase_items < phase_target; phase_items++) begin
				req = next_bus_request();
				send_request(req, 0, '0);
			end
		end

		settle_bus();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/owbm_pkg.sv
design/owbm_step.sv
design/one_wire_bus_master.sv
sim/one_wire_bus_master_tb.sv
